>>> rtl/core/box_overlap_separating_axis_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the box overlap block
// Concurrent checks on clk, with and without a reset guard.
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_SEPARATING_AXIS_ASSERT_SVH
`define BOX_OVERLAP_SEPARATING_AXIS_ASSERT_SVH

// check outside of reset
`define BOSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers reset cycles
`define BOSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bosa_pkg.sv
// ---------------------------------------------------------------------------
// bosa_pkg
// Widths, types, codes and helpers shared by the box overlap pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bosa_pkg;

  localparam int COORD_BITS  = 21;
  localparam int ORIENT_BITS = 16;
  localparam int HALF_BITS   = COORD_BITS - 1;
  localparam int FRAC_O      = ORIENT_BITS - 2;
  localparam int LIMIT_BITS  = 40;

  localparam int CENTER_VEC_BITS = 3 * COORD_BITS;
  localparam int HALF_VEC_BITS   = 3 * HALF_BITS;
  localparam int ORIENT_VEC_BITS = 3 * ORIENT_BITS;
  localparam int CFG_BITS_A = (CENTER_VEC_BITS > ORIENT_VEC_BITS) ?
                              CENTER_VEC_BITS : ORIENT_VEC_BITS;
  localparam int CFG_BITS   = (CFG_BITS_A > LIMIT_BITS) ? CFG_BITS_A : LIMIT_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam int NUM_AXES = 15;
  localparam int NUM_FACE = 6;
  localparam int AXIS_IDX_BITS = 4;
  localparam logic [AXIS_IDX_BITS-1:0] AXIS_NONE = AXIS_IDX_BITS'(NUM_AXES);

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PQ_BITS   = 2 * ORIENT_BITS;
  localparam int LAX_BITS  = 2 * ORIENT_BITS + 1;
  localparam int DPP_BITS  = DIFF_BITS + LAX_BITS;
  localparam int DP_BITS   = DPP_BITS + 2;
  localparam int AXP_BITS  = ORIENT_BITS + LAX_BITS;
  localparam int AXD_BITS  = AXP_BITS + 2;
  localparam int HM_BITS   = HALF_BITS + AXD_BITS;
  localparam int RAD_BITS  = HM_BITS + 3;
  localparam int SQP_BITS  = 2 * LAX_BITS;
  localparam int SQ_BITS   = 64;

  localparam int FACE_SHIFT  = 56 - 2 * FRAC_O;
  localparam int CROSS_SHIFT = 56 - 4 * FRAC_O;

  localparam logic [CFG_IDX_BITS-1:0] REG_REF_CENTER = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_HALF   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_AXIS_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_AXIS_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_REF_AXIS_Z = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEG_LIMIT  = 3'd5;

  localparam logic [ORIENT_VEC_BITS-1:0] ORIENT_ONE =
    ORIENT_VEC_BITS'(1) << FRAC_O;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(72058);

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic        [HALF_BITS-1:0]   half_t;
  typedef logic signed [ORIENT_BITS-1:0] ori_t;
  typedef logic        [ORIENT_VEC_BITS-1:0] ovec_t;
  typedef logic signed [DIFF_BITS-1:0]   diff_t;
  typedef logic signed [PQ_BITS-1:0]     pq_t;
  typedef logic signed [LAX_BITS-1:0]    lax_t;
  typedef logic signed [DPP_BITS-1:0]    dpp_t;
  typedef logic signed [DP_BITS-1:0]     dp_t;
  typedef logic        [DP_BITS-1:0]     dpm_t;
  typedef logic signed [AXP_BITS-1:0]    axp_t;
  typedef logic signed [AXD_BITS-1:0]    axd_t;
  typedef logic        [AXD_BITS-1:0]    axm_t;
  typedef logic        [HM_BITS-1:0]     hm_t;
  typedef logic        [RAD_BITS-1:0]    rad_t;
  typedef logic signed [SQP_BITS-1:0]    sqp_t;
  typedef logic        [SQ_BITS-1:0]     sq_t;

  function automatic ori_t orient_comp(input ovec_t v, input int k);
    orient_comp = v[k*ORIENT_BITS +: ORIENT_BITS];
  endfunction

  function automatic coord_t center_comp(input logic [CENTER_VEC_BITS-1:0] v,
                                         input int k);
    center_comp = v[k*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic half_t half_comp(input logic [HALF_VEC_BITS-1:0] v, input int k);
    half_comp = v[k*HALF_BITS +: HALF_BITS];
  endfunction

endpackage

>>> rtl/core/bosa_if.sv
// ---------------------------------------------------------------------------
// Box overlap channels
// Request channel carrying one tested box, result channel carrying a verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bosa_query_if;
  logic                   valid;
  logic                   ready;
  bosa_pkg::coord_t       center_x;
  bosa_pkg::coord_t       center_y;
  bosa_pkg::coord_t       center_z;
  bosa_pkg::half_t        half_x;
  bosa_pkg::half_t        half_y;
  bosa_pkg::half_t        half_z;
  bosa_pkg::ovec_t        orient_col0;
  bosa_pkg::ovec_t        orient_col1;
  bosa_pkg::ovec_t        orient_col2;

  modport src (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
               orient_col0, orient_col1, orient_col2, input ready);
  modport snk (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
               orient_col0, orient_col1, orient_col2, output ready);
endinterface

interface bosa_verdict_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   overlapping;
  logic [bosa_pkg::AXIS_IDX_BITS-1:0]     separating_axis;

  modport src (output valid, overlapping, separating_axis, input ready);
  modport snk (input valid, overlapping, separating_axis, output ready);
endinterface

>>> rtl/core/bosa_axes.sv
// ---------------------------------------------------------------------------
// bosa_axes
// Two stages: center difference and cross partial products, then the
// fifteen candidate axes in test order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosa_axes (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bosa_pkg::coord_t    center [3],
  input  bosa_pkg::half_t     half [3],
  input  bosa_pkg::ovec_t     orient [3],
  input  logic [bosa_pkg::CENTER_VEC_BITS-1:0] ref_center,
  input  bosa_pkg::ovec_t     ref_axis [3],
  output logic                out_valid,
  input  logic                out_ready,
  output bosa_pkg::lax_t      lax [bosa_pkg::NUM_AXES][3],
  output bosa_pkg::diff_t     diff [3],
  output bosa_pkg::half_t     half_b [3],
  output bosa_pkg::ori_t      axb [3][3]
);

  logic v1, v2, en1, en2;
  bosa_pkg::ori_t  ta [3][3];
  bosa_pkg::ori_t  tb [3][3];
  bosa_pkg::diff_t diff1 [3];
  bosa_pkg::half_t half1 [3];
  bosa_pkg::ori_t  axb1 [3][3];
  bosa_pkg::pq_t   pq1 [3][3][3][2];

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ta[i][k] = bosa_pkg::orient_comp(ref_axis[i], k);
        tb[i][k] = bosa_pkg::orient_comp(orient[i], k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        diff1[k] <= bosa_pkg::DIFF_BITS'(center[k])
                  - bosa_pkg::DIFF_BITS'(bosa_pkg::center_comp(ref_center, k));
        half1[k] <= half[k];
        for (int j = 0; j < 3; j++) axb1[j][k] <= tb[j][k];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pq1[i][j][k][0] <= ta[i][(k+1)%3] * tb[j][(k+2)%3];
            pq1[i][j][k][1] <= ta[i][(k+2)%3] * tb[j][(k+1)%3];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        diff[k]   <= diff1[k];
        half_b[k] <= half1[k];
        for (int i = 0; i < 3; i++) begin
          axb[i][k]       <= axb1[i][k];
          lax[2*i][k]     <= bosa_pkg::LAX_BITS'(ta[i][k]);
          lax[2*i+1][k]   <= bosa_pkg::LAX_BITS'(axb1[i][k]);
          for (int j = 0; j < 3; j++) begin
            lax[bosa_pkg::NUM_FACE + 3*i + j][k] <= pq1[i][j][k][0] - pq1[i][j][k][1];
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/bosa_proj.sv
// ---------------------------------------------------------------------------
// bosa_proj
// Five stages per axis: projection products, dot sums, magnitudes and
// radius terms, radius sum, then the separation test with length screen.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosa_proj (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bosa_pkg::lax_t      lax [bosa_pkg::NUM_AXES][3],
  input  bosa_pkg::diff_t     diff [3],
  input  bosa_pkg::half_t     half_b [3],
  input  bosa_pkg::ori_t      axb [3][3],
  input  logic [bosa_pkg::HALF_VEC_BITS-1:0] ref_half,
  input  bosa_pkg::ovec_t     ref_axis [3],
  input  logic [bosa_pkg::LIMIT_BITS-1:0]    limit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [bosa_pkg::NUM_AXES-1:0]      sep
);

  localparam int NA = bosa_pkg::NUM_AXES;
  localparam int NS = 5;

  logic [NS-1:0] v, en;

  bosa_pkg::ori_t  ta [3][3];
  bosa_pkg::half_t ha [3];

  bosa_pkg::dpp_t  dpp3 [NA][3];
  bosa_pkg::axp_t  pa3 [NA][3][3];
  bosa_pkg::axp_t  pb3 [NA][3][3];
  bosa_pkg::sqp_t  sq3 [NA][3];
  bosa_pkg::half_t hb3 [3];

  bosa_pkg::dp_t   dp4 [NA];
  bosa_pkg::axd_t  da4 [NA][3];
  bosa_pkg::axd_t  db4 [NA][3];
  bosa_pkg::sq_t   sql4 [NA];
  bosa_pkg::half_t hb4 [3];

  bosa_pkg::dpm_t  dpm4 [NA];
  bosa_pkg::axm_t  dam4 [NA][3];
  bosa_pkg::axm_t  dbm4 [NA][3];
  bosa_pkg::sq_t   sqs4 [NA];

  bosa_pkg::dpm_t  dpm5 [NA];
  bosa_pkg::hm_t   ra5 [NA][3];
  bosa_pkg::hm_t   rb5 [NA][3];
  logic [NA-1:0]   keep5;

  bosa_pkg::dpm_t  dpm6 [NA];
  bosa_pkg::rad_t  rad6 [NA];
  logic [NA-1:0]   keep6;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ha[i] = bosa_pkg::half_comp(ref_half, i);
      for (int k = 0; k < 3; k++) ta[i][k] = bosa_pkg::orient_comp(ref_axis[i], k);
    end
  end

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      dpm4[a] = dp4[a][bosa_pkg::DP_BITS-1] ? bosa_pkg::DP_BITS'(-dp4[a])
                                             : bosa_pkg::DP_BITS'(dp4[a]);
      sqs4[a] = bosa_pkg::SQ_BITS'(sql4[a] << ((a < bosa_pkg::NUM_FACE) ?
                bosa_pkg::FACE_SHIFT : bosa_pkg::CROSS_SHIFT));
      for (int i = 0; i < 3; i++) begin
        dam4[a][i] = da4[a][i][bosa_pkg::AXD_BITS-1] ?
                     bosa_pkg::AXD_BITS'(-da4[a][i]) : bosa_pkg::AXD_BITS'(da4[a][i]);
        dbm4[a][i] = db4[a][i][bosa_pkg::AXD_BITS-1] ?
                     bosa_pkg::AXD_BITS'(-db4[a][i]) : bosa_pkg::AXD_BITS'(db4[a][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) hb3[k] <= half_b[k];
      for (int a = 0; a < NA; a++) begin
        for (int k = 0; k < 3; k++) begin
          dpp3[a][k] <= diff[k] * lax[a][k];
          sq3[a][k]  <= lax[a][k] * lax[a][k];
          for (int i = 0; i < 3; i++) begin
            pa3[a][i][k] <= ta[i][k] * lax[a][k];
            pb3[a][i][k] <= axb[i][k] * lax[a][k];
          end
        end
      end
    end
    if (en[1]) begin
      for (int k = 0; k < 3; k++) hb4[k] <= hb3[k];
      for (int a = 0; a < NA; a++) begin
        dp4[a]  <= dpp3[a][0] + dpp3[a][1] + dpp3[a][2];
        sql4[a] <= bosa_pkg::SQ_BITS'(sq3[a][0] + sq3[a][1] + sq3[a][2]);
        for (int i = 0; i < 3; i++) begin
          da4[a][i] <= pa3[a][i][0] + pa3[a][i][1] + pa3[a][i][2];
          db4[a][i] <= pb3[a][i][0] + pb3[a][i][1] + pb3[a][i][2];
        end
      end
    end
    if (en[2]) begin
      for (int a = 0; a < NA; a++) begin
        dpm5[a]  <= dpm4[a];
        keep5[a] <= sqs4[a] >= bosa_pkg::SQ_BITS'(limit);
        for (int i = 0; i < 3; i++) begin
          ra5[a][i] <= ha[i] * dam4[a][i];
          rb5[a][i] <= hb4[i] * dbm4[a][i];
        end
      end
    end
    if (en[3]) begin
      for (int a = 0; a < NA; a++) begin
        dpm6[a]  <= dpm5[a];
        keep6[a] <= keep5[a];
        rad6[a]  <= bosa_pkg::RAD_BITS'(ra5[a][0]) + bosa_pkg::RAD_BITS'(ra5[a][1])
                  + bosa_pkg::RAD_BITS'(ra5[a][2]) + bosa_pkg::RAD_BITS'(rb5[a][0])
                  + bosa_pkg::RAD_BITS'(rb5[a][1]) + bosa_pkg::RAD_BITS'(rb5[a][2]);
      end
    end
    if (en[4]) begin
      for (int a = 0; a < NA; a++) begin
        sep[a] <= keep6[a] && (bosa_pkg::RAD_BITS'(dpm6[a]) > rad6[a]);
      end
    end
  end

endmodule

>>> rtl/core/bosa_pick.sv
// ---------------------------------------------------------------------------
// bosa_pick
// Select the first separating axis in test order and hold the verdict
// in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "box_overlap_separating_axis_assert.svh"

module bosa_pick (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bosa_pkg::NUM_AXES-1:0]        sep,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 overlapping,
  output logic [bosa_pkg::AXIS_IDX_BITS-1:0]   separating_axis
);

  logic en;
  logic [bosa_pkg::AXIS_IDX_BITS-1:0] first;

  assign en = !res_valid || res_ready;
  assign in_ready = en;

  always_comb begin
    first = bosa_pkg::AXIS_NONE;
    for (int a = bosa_pkg::NUM_AXES - 1; a >= 0; a--) begin
      if (sep[a]) first = bosa_pkg::AXIS_IDX_BITS'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlapping     <= (first == bosa_pkg::AXIS_NONE);
      separating_axis <= first;
    end
  end

  `BOSA_ASSERT_RST(a_reset_clears, rst |=> !res_valid, "verdict valid after reset")
  `BOSA_ASSERT(a_take_lands, (in_valid && in_ready) |=> res_valid, "taken request lost")
  `BOSA_ASSERT(a_flag_axis, res_valid |-> (overlapping == (separating_axis == bosa_pkg::AXIS_NONE)), "overlap flag and axis disagree")
  `BOSA_ASSERT(a_no_sep, (in_valid && in_ready && (sep == '0)) |=> overlapping, "overlap missed with no separating axis")

endmodule

>>> rtl/core/box_overlap_separating_axis.sv
// ---------------------------------------------------------------------------
// box_overlap_separating_axis
// Oriented box overlap test against a configured reference box.
// ---------------------------------------------------------------------------
// Usage:
//   query   : one tested box per request (center, half extents, orientation
//             columns), accepted when valid and ready are both high.
//   verdict : overlapping flag and the index of the first separating axis
//             (15 when the boxes overlap or touch).
//   cfg_*   : write port for the reference box and the degenerate axis
//             limit; write only while no request is in flight.
// Throughput: one request per cycle unless the verdict stalls, set by the
//   fully pipelined per-axis projection datapath; all fifteen axes are
//   evaluated in parallel.
// Pipeline: eight register stages (two axis stages, five projection stages,
//   one output register, the first loaded at the accepting edge).
// Reset: empties every pipeline stage; the reference box becomes a zero box
//   with identity orientation and the default degenerate limit.
// Stall: when verdict.ready is low, requests keep moving into empty stages
//   behind the held verdict; query.ready drops only once every stage is
//   full. Nothing is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_overlap_separating_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bosa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bosa_pkg::CFG_BITS-1:0]       cfg_data,
  bosa_query_if.snk                           query,
  bosa_verdict_if.src                         verdict
);

  logic [bosa_pkg::CENTER_VEC_BITS-1:0] ref_center;
  logic [bosa_pkg::HALF_VEC_BITS-1:0]   ref_half;
  bosa_pkg::ovec_t                      ref_axis [3];
  logic [bosa_pkg::LIMIT_BITS-1:0]      deg_limit;

  bosa_pkg::coord_t center [3];
  bosa_pkg::half_t  half [3];
  bosa_pkg::ovec_t  orient [3];

  logic ax_valid, ax_ready, pj_valid, pj_ready;
  bosa_pkg::lax_t  lax [bosa_pkg::NUM_AXES][3];
  bosa_pkg::diff_t diff [3];
  bosa_pkg::half_t half_b [3];
  bosa_pkg::ori_t  axb [3][3];
  logic [bosa_pkg::NUM_AXES-1:0] sep;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_center  <= '0;
      ref_half    <= '0;
      ref_axis[0] <= bosa_pkg::ORIENT_ONE;
      ref_axis[1] <= bosa_pkg::ORIENT_ONE << bosa_pkg::ORIENT_BITS;
      ref_axis[2] <= bosa_pkg::ORIENT_ONE << (2 * bosa_pkg::ORIENT_BITS);
      deg_limit   <= bosa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bosa_pkg::REG_REF_CENTER: ref_center  <= cfg_data[bosa_pkg::CENTER_VEC_BITS-1:0];
        bosa_pkg::REG_REF_HALF:   ref_half    <= cfg_data[bosa_pkg::HALF_VEC_BITS-1:0];
        bosa_pkg::REG_REF_AXIS_X: ref_axis[0] <= cfg_data[bosa_pkg::ORIENT_VEC_BITS-1:0];
        bosa_pkg::REG_REF_AXIS_Y: ref_axis[1] <= cfg_data[bosa_pkg::ORIENT_VEC_BITS-1:0];
        bosa_pkg::REG_REF_AXIS_Z: ref_axis[2] <= cfg_data[bosa_pkg::ORIENT_VEC_BITS-1:0];
        bosa_pkg::REG_DEG_LIMIT:  deg_limit   <= cfg_data[bosa_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign center[0] = query.center_x;
  assign center[1] = query.center_y;
  assign center[2] = query.center_z;
  assign half[0]   = query.half_x;
  assign half[1]   = query.half_y;
  assign half[2]   = query.half_z;
  assign orient[0] = query.orient_col0;
  assign orient[1] = query.orient_col1;
  assign orient[2] = query.orient_col2;

  bosa_axes u_axes (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .center     (center),
    .half       (half),
    .orient     (orient),
    .ref_center (ref_center),
    .ref_axis   (ref_axis),
    .out_valid  (ax_valid),
    .out_ready  (ax_ready),
    .lax        (lax),
    .diff       (diff),
    .half_b     (half_b),
    .axb        (axb)
  );

  bosa_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ax_valid),
    .in_ready  (ax_ready),
    .lax       (lax),
    .diff      (diff),
    .half_b    (half_b),
    .axb       (axb),
    .ref_half  (ref_half),
    .ref_axis  (ref_axis),
    .limit     (deg_limit),
    .out_valid (pj_valid),
    .out_ready (pj_ready),
    .sep       (sep)
  );

  bosa_pick u_pick (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (pj_valid),
    .in_ready        (pj_ready),
    .sep             (sep),
    .res_valid       (verdict.valid),
    .res_ready       (verdict.ready),
    .overlapping     (verdict.overlapping),
    .separating_axis (verdict.separating_axis)
  );

endmodule
